// ===== sv/lptc_pkg.sv =====
// shared widths, constants and types for the polar to cartesian converter
`default_nettype none

package lptc_pkg;

    localparam int ANGLE_W    = 16;
    localparam int DIST_W     = 18;
    localparam int MM_W       = 16;
    localparam int COORD_W    = 21;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    localparam int CORDIC_ITERS = 24;
    localparam int XY_W         = 49;
    localparam int Z_W          = 33;
    localparam int KGAIN_W      = 30;
    localparam int PROD_W       = MM_W + KGAIN_W;
    localparam int FRAC_SHIFT   = 26;
    localparam int ROUND_W      = XY_W - FRAC_SHIFT;

    // inverse cordic gain, q30
    localparam logic [KGAIN_W-1:0] KGAIN = KGAIN_W'(652032874);
    localparam logic signed [ROUND_W-1:0] OUT_LIMIT = ROUND_W'(1048560);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0]  t_z;

    typedef struct packed {
        t_xy        x;
        t_xy        y;
        t_z         z;
        logic [1:0] quad;
        logic       last;
    } t_vec;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn32(input int unsigned idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'd536870912;
            1:       v = 30'd316933406;
            2:       v = 30'd167458907;
            3:       v = 30'd85004756;
            4:       v = 30'd42667331;
            5:       v = 30'd21354465;
            6:       v = 30'd10679830;
            7:       v = 30'd5340245;
            8:       v = 30'd2670163;
            9:       v = 30'd1335087;
            10:      v = 30'd667544;
            11:      v = 30'd333772;
            12:      v = 30'd166886;
            13:      v = 30'd83443;
            14:      v = 30'd41722;
            15:      v = 30'd20861;
            16:      v = 30'd10430;
            17:      v = 30'd5215;
            18:      v = 30'd2608;
            19:      v = 30'd1304;
            20:      v = 30'd652;
            21:      v = 30'd326;
            22:      v = 30'd163;
            23:      v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lptc_prep.sv =====
// entry stage: scales the distance by the inverse gain and splits the angle
`default_nettype none

module lptc_prep
    import lptc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [ANGLE_W-1:0] i_angle,
    input  wire logic [DIST_W-1:0]  i_dist,
    input  wire logic              i_last,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_vec                   o_data
);

    logic              r_valid;
    t_vec              r_data;
    t_vec              n_data;
    logic [MM_W-1:0]   d_mm;
    logic [PROD_W-1:0] prod;

    assign o_ready = !r_valid || i_ready;
    assign d_mm    = i_dist[DIST_W-1:DIST_W-MM_W];
    assign prod    = PROD_W'(d_mm) * PROD_W'(KGAIN);

    always_comb begin
        n_data.x    = t_xy'(prod);
        n_data.y    = '0;
        n_data.z    = t_z'({i_angle[ANGLE_W-3:0], 16'd0});
        n_data.quad = i_angle[ANGLE_W-1:ANGLE_W-2];
        n_data.last = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== sv/lptc_cell.sv =====
// one cordic rotation step with its own item register
`default_nettype none

module lptc_cell
    import lptc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_vec i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_vec      o_data
);

    localparam t_z ATAN_STEP = t_z'(atan_turn32(STAGE));

    logic r_valid;
    t_vec r_data;
    t_vec n_data;
    t_xy  dx;
    t_xy  dy;

    assign o_ready = !r_valid || i_ready;
    assign dx      = i_data.y >>> STAGE;
    assign dy      = i_data.x >>> STAGE;

    always_comb begin
        n_data = i_data;
        // rotate towards zero residual angle
        if (!i_data.z[Z_W-1]) begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ATAN_STEP;
        end else begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== sv/lptc_post.sv =====
// exit stage: rounds to 1/16 mm, unfolds the quadrant and saturates
`default_nettype none

module lptc_post
    import lptc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_vec              i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [COORD_W-1:0]     o_x,
    output logic [COORD_W-1:0]     o_y,
    output logic                   o_last
);

    logic                       r_valid;
    logic [COORD_W-1:0]         r_x;
    logic [COORD_W-1:0]         r_y;
    logic                       r_last;
    t_xy                        x_rnd;
    t_xy                        y_rnd;
    logic signed [ROUND_W-1:0]  c;
    logic signed [ROUND_W-1:0]  s;
    logic signed [ROUND_W-1:0]  xo;
    logic signed [ROUND_W-1:0]  yo;

    function automatic logic [COORD_W-1:0] sat(input logic signed [ROUND_W-1:0] v);
        logic signed [ROUND_W-1:0] t;
        t = v;
        if (v > OUT_LIMIT) begin
            t = OUT_LIMIT;
        end else if (v < -OUT_LIMIT) begin
            t = -OUT_LIMIT;
        end
        return t[COORD_W-1:0];
    endfunction

    assign o_ready = !r_valid || i_ready;

    // round half up then drop the q26 fraction
    assign x_rnd = i_data.x + t_xy'(1 <<< (FRAC_SHIFT - 1));
    assign y_rnd = i_data.y + t_xy'(1 <<< (FRAC_SHIFT - 1));
    assign c     = x_rnd[XY_W-1:FRAC_SHIFT];
    assign s     = y_rnd[XY_W-1:FRAC_SHIFT];

    always_comb begin
        unique case (i_data.quad)
            QUAD_0: begin
                xo = c;
                yo = s;
            end
            QUAD_1: begin
                xo = -s;
                yo = c;
            end
            QUAD_2: begin
                xo = -c;
                yo = -s;
            end
            QUAD_3: begin
                xo = s;
                yo = -c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_x    <= sat(xo);
            r_y    <= sat(yo);
            r_last <= i_data.last;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_last  = r_last;

    a_x_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($signed(r_x) <= 21'sd1048560 && $signed(r_x) >= -21'sd1048560))
        else $error("x result outside saturation bound");

    a_y_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($signed(r_y) <= 21'sd1048560 && $signed(r_y) >= -21'sd1048560))
        else $error("y result outside saturation bound");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> r_valid)
        else $error("waiting result dropped");

    a_ready_only_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_valid && !i_ready))
        else $error("exit stage refused an item with room free");

endmodule

`default_nettype wire

// ===== sv/lidar_polar_to_cartesian.sv =====
// top level: range-scanner point to x/y conversion through a chain of cordic cells
//
//  channel  | direction | tdata (lowest bit up)                      | tlast
//  s_axis   | in        | angle_raw[15:0], distance_raw[33:16], pad  | last_of_scan
//  m_axis   | out       | x_pos[20:0], y_pos[41:21], pad             | scan_end
//
// one item per cycle while m_axis_tready is high; stages: entry multiply, 24 rotation cells, exit rounding
// the rotation chain has 24 cells, every cell holds one item
// reset clears the valid bit of every stage; payload registers are not reset
// a full stage holds while the stage after it is full and stalled; empty stages close up,
// so items are still taken while a result waits at the output

`default_nettype none

module lidar_polar_to_cartesian
    import lptc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // angle_raw, distance_raw
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // x_pos, y_pos
    output logic                       m_axis_tlast
);

    logic               chain_valid [CORDIC_ITERS+1];
    logic               chain_ready [CORDIC_ITERS+1];
    t_vec               chain_data  [CORDIC_ITERS+1];
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;

    lptc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_angle (s_axis_tdata[ANGLE_W-1:0]),
        .i_dist  (s_axis_tdata[ANGLE_W+DIST_W-1:ANGLE_W]),
        .i_last  (s_axis_tlast),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_data  (chain_data[0])
    );

    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
        lptc_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    lptc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[CORDIC_ITERS]),
        .o_ready (chain_ready[CORDIC_ITERS]),
        .i_data  (chain_data[CORDIC_ITERS]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_x     (x_pos),
        .o_y     (y_pos),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_DATA_W - 2*COORD_W)'(0), y_pos, x_pos};

endmodule

`default_nettype wire
